// File: rtl/rtll_pkg.sv
// ----------------------------------------------------------------------------
// rtll_pkg
// Shared types and codes for the remote table with per-remote link lists.
// ----------------------------------------------------------------------------
package rtll_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int LINKS_DEF   = 8;
    localparam int ADDR_W      = 24;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_LINK   = 3'd2;
    localparam logic [2:0] REQ_UNLINK = 3'd3;
    localparam logic [2:0] REQ_LOOKUP = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_PRESENT    = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_LINKED     = 3'd4;
    localparam logic [2:0] ST_LINKS_FULL = 3'd5;
    localparam logic [2:0] ST_NOT_LINKED = 3'd6;
    localparam logic [2:0] ST_UNUSED     = 3'd7;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [ADDR_W-1:0] remote_addr;
        logic [ADDR_W-1:0] device_addr;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] link_count;
        logic [4:0] active_count;
    } t_rsp;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_ADD,
        FIN_REMOVE,
        FIN_LINK,
        FIN_UNLINK,
        FIN_REPORT
    } t_fin;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan_step;
        logic       lscan_start;
        logic       lscan_step;
        logic       shift_start;
        logic       shift_step;
        t_fin       fin;
        logic [2:0] rsp_status;
        logic       cnt_hit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req_type;
        logic       hit;
        logic       free_ok;
        logic       scan_done;
        logic       lfound;
        logic       lscan_done;
        logic       cnt_full;
        logic       shift_needed;
        logic       shift_done;
        logic       out_free;
    } t_stat;

endpackage

// File: rtl/rtll_ctrl.sv
// ----------------------------------------------------------------------------
// rtll_ctrl
// Request sequencer: slot scan, link scan, list shift and completion.
// ----------------------------------------------------------------------------
module rtll_ctrl
    import rtll_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    input  t_stat i_stat,
    output logic  o_req_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LSCAN,
        S_SHIFT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        t_fin       v_fin;
        logic [2:0] v_st;
        logic       v_cnt;
        v_fin   = FIN_NONE;
        v_st    = ST_OK;
        v_cnt   = 1'b0;
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.fin = FIN_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && r_ready) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    case (i_stat.req_type)
                        REQ_ADD: begin
                            if (i_stat.hit) begin
                                v_fin = FIN_REPORT;
                                v_st  = ST_PRESENT;
                                v_cnt = 1'b1;
                            end else if (!i_stat.free_ok) begin
                                v_fin = FIN_REPORT;
                                v_st  = ST_TABLE_FULL;
                            end else begin
                                v_fin = FIN_ADD;
                            end
                        end
                        REQ_REMOVE: begin
                            if (!i_stat.hit) begin
                                v_fin = FIN_REPORT;
                                v_st  = ST_NOT_FOUND;
                            end else begin
                                v_fin = FIN_REMOVE;
                            end
                        end
                        REQ_LINK, REQ_UNLINK: begin
                            if (!i_stat.hit) begin
                                v_fin = FIN_REPORT;
                                v_st  = ST_NOT_FOUND;
                            end else begin
                                o_cmd.lscan_start = 1'b1;
                                n_state           = S_LSCAN;
                            end
                        end
                        default: begin
                            v_fin = FIN_REPORT;
                            v_st  = i_stat.hit ? ST_OK : ST_NOT_FOUND;
                            v_cnt = i_stat.hit;
                        end
                    endcase
                end
            end
            S_LSCAN: begin
                o_cmd.lscan_step = 1'b1;
                if (i_stat.lscan_done) begin
                    if (i_stat.req_type == REQ_LINK) begin
                        if (i_stat.lfound) begin
                            v_fin = FIN_REPORT;
                            v_st  = ST_LINKED;
                            v_cnt = 1'b1;
                        end else if (i_stat.cnt_full) begin
                            v_fin = FIN_REPORT;
                            v_st  = ST_LINKS_FULL;
                            v_cnt = 1'b1;
                        end else begin
                            v_fin = FIN_LINK;
                        end
                    end else begin
                        if (!i_stat.lfound) begin
                            v_fin = FIN_REPORT;
                            v_st  = ST_NOT_LINKED;
                            v_cnt = 1'b1;
                        end else if (i_stat.shift_needed) begin
                            o_cmd.shift_start = 1'b1;
                            n_state           = S_SHIFT;
                        end else begin
                            v_fin = FIN_UNLINK;
                        end
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_done) begin
                    v_fin = FIN_UNLINK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // hold completion until the response register can take it
        if (v_fin != FIN_NONE && i_stat.out_free) begin
            o_cmd.fin        = v_fin;
            o_cmd.rsp_status = v_st;
            o_cmd.cnt_hit    = v_cnt;
            n_state          = S_IDLE;
        end
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_req_ready = r_ready;

endmodule

// File: rtl/rtll_dpath.sv
// ----------------------------------------------------------------------------
// rtll_dpath
// Slot and link memories, scan counters, active bits and response register.
// ----------------------------------------------------------------------------
module rtll_dpath
    import rtll_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int LINKS   = LINKS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    input  logic  i_rsp_ready,
    output t_stat o_stat,
    output logic  o_rsp_valid,
    output t_rsp  o_rsp
);

    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW     = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int SW     = $clog2(ENTRIES + 1);
    localparam int CW     = $clog2(LINKS + 1);
    localparam int LDEPTH = 1 << (IW + LW);

    typedef struct packed {
        logic [CW-1:0]     cnt;
        logic [ADDR_W-1:0] addr;
    } t_slot;

    t_slot             m_slot [ENTRIES];
    logic [ADDR_W-1:0] m_link [LDEPTH];

    t_req              r_req;
    t_slot             r_slot_q;
    logic [ADDR_W-1:0] r_link_q;
    logic [ENTRIES-1:0] r_active;
    logic [SW-1:0]     r_act_cnt;
    logic [SW-1:0]     n_act_cnt;
    logic [SW-1:0]     r_sidx;
    logic [IW-1:0]     r_spidx;
    logic              r_spend;
    logic              r_hit;
    logic [IW-1:0]     r_hit_idx;
    logic [CW-1:0]     r_hit_cnt;
    logic              r_free_ok;
    logic [IW-1:0]     r_free_idx;
    logic [CW-1:0]     r_lidx;
    logic [LW-1:0]     r_lpidx;
    logic              r_lpend;
    logic              r_lfound;
    logic [LW-1:0]     r_lpos;
    logic              r_out_valid;
    t_rsp              r_rsp;
    t_rsp              n_rsp;

    logic              hit_now;
    logic              free_now;
    logic              scan_issue;
    logic              lhit_now;
    logic              l_issue;
    logic              shift_issue;
    logic              slot_we;
    logic [IW-1:0]     slot_wa;
    t_slot             slot_wd;
    logic              link_we;
    logic [IW+LW-1:0]  link_wa;
    logic [ADDR_W-1:0] link_wd;
    logic [IW+LW-1:0]  link_ra;
    logic [CW-1:0]     v_cnt;

    assign hit_now  = r_spend && !r_hit && r_active[r_spidx]
                      && (r_slot_q.addr == r_req.remote_addr);
    assign free_now = r_spend && !r_free_ok && !r_active[r_spidx];
    assign scan_issue = i_cmd.scan_step && !r_hit && !hit_now
                        && (r_sidx != SW'(ENTRIES));

    assign lhit_now = i_cmd.lscan_step && r_lpend && !r_lfound
                      && (r_link_q == r_req.device_addr);
    assign l_issue  = i_cmd.lscan_step && !r_lfound && !lhit_now
                      && (r_lidx != r_hit_cnt);
    assign shift_issue = i_cmd.shift_step && (r_lidx != r_hit_cnt);
    assign link_ra = {r_hit_idx, r_lidx[LW-1:0]};

    always_comb begin
        case (i_cmd.fin)
            FIN_ADD:    n_act_cnt = r_act_cnt + SW'(1);
            FIN_REMOVE: n_act_cnt = r_act_cnt - SW'(1);
            default:    n_act_cnt = r_act_cnt;
        endcase
        case (i_cmd.fin)
            FIN_LINK:   v_cnt = r_hit_cnt + CW'(1);
            FIN_UNLINK: v_cnt = r_hit_cnt - CW'(1);
            FIN_REPORT: v_cnt = i_cmd.cnt_hit ? r_hit_cnt : '0;
            default:    v_cnt = '0;
        endcase
        n_rsp.status       = (i_cmd.fin == FIN_REPORT) ? i_cmd.rsp_status : ST_OK;
        n_rsp.link_count   = 4'(v_cnt);
        n_rsp.active_count = 5'(n_act_cnt);

        slot_we      = (i_cmd.fin == FIN_ADD) || (i_cmd.fin == FIN_LINK)
                       || (i_cmd.fin == FIN_UNLINK);
        slot_wa      = (i_cmd.fin == FIN_ADD) ? r_free_idx : r_hit_idx;
        slot_wd.cnt  = v_cnt;
        slot_wd.addr = r_req.remote_addr;

        link_we = (i_cmd.fin == FIN_LINK) || (i_cmd.shift_step && r_lpend);
        if (i_cmd.fin == FIN_LINK) begin
            link_wa = {r_hit_idx, r_hit_cnt[LW-1:0]};
            link_wd = r_req.device_addr;
        end else begin
            link_wa = {r_hit_idx, LW'(r_lpidx - LW'(1))};
            link_wd = r_link_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            m_slot[slot_wa] <= slot_wd;
        end
        if (scan_issue) begin
            r_slot_q <= m_slot[r_sidx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            m_link[link_wa] <= link_wd;
        end
        if (l_issue || shift_issue) begin
            r_link_q <= m_link[link_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (scan_issue) begin
            r_spidx <= r_sidx[IW-1:0];
        end
        if (hit_now) begin
            r_hit_idx <= r_spidx;
            r_hit_cnt <= r_slot_q.cnt;
        end
        if (free_now) begin
            r_free_idx <= r_spidx;
        end
        if (l_issue || shift_issue) begin
            r_lpidx <= r_lidx[LW-1:0];
        end
        if (lhit_now) begin
            r_lpos <= r_lpidx;
        end
        if (i_cmd.fin != FIN_NONE) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_act_cnt   <= '0;
            r_sidx      <= '0;
            r_spend     <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_lidx      <= '0;
            r_lpend     <= 1'b0;
            r_lfound    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_sidx    <= '0;
                r_spend   <= 1'b0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
                if (free_now) begin
                    r_free_ok <= 1'b1;
                end
                r_spend <= scan_issue;
                if (scan_issue) begin
                    r_sidx <= r_sidx + SW'(1);
                end
            end

            if (i_cmd.lscan_start) begin
                r_lidx   <= '0;
                r_lpend  <= 1'b0;
                r_lfound <= 1'b0;
            end else if (i_cmd.shift_start) begin
                r_lidx  <= CW'(r_lpos) + CW'(1);
                r_lpend <= 1'b0;
            end else if (i_cmd.lscan_step) begin
                if (lhit_now) begin
                    r_lfound <= 1'b1;
                end
                r_lpend <= l_issue;
                if (l_issue) begin
                    r_lidx <= r_lidx + CW'(1);
                end
            end else if (i_cmd.shift_step) begin
                r_lpend <= shift_issue;
                if (shift_issue) begin
                    r_lidx <= r_lidx + CW'(1);
                end
            end

            case (i_cmd.fin)
                FIN_ADD:    r_active[r_free_idx] <= 1'b1;
                FIN_REMOVE: r_active[r_hit_idx]  <= 1'b0;
                default:    r_active <= r_active;
            endcase
            r_act_cnt <= n_act_cnt;

            if (i_cmd.fin != FIN_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req_type     = r_req.req_type;
    assign o_stat.hit          = r_hit;
    assign o_stat.free_ok      = r_free_ok;
    assign o_stat.scan_done    = !r_spend && (r_hit || (r_sidx == SW'(ENTRIES)));
    assign o_stat.lfound       = r_lfound;
    assign o_stat.lscan_done   = !r_lpend && (r_lfound || (r_lidx == r_hit_cnt));
    assign o_stat.cnt_full     = (r_hit_cnt >= CW'(LINKS));
    assign o_stat.shift_needed = ((CW'(r_lpos) + CW'(1)) < r_hit_cnt);
    assign o_stat.shift_done   = !r_lpend && (r_lidx == r_hit_cnt);
    assign o_stat.out_free     = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

// File: rtl/remote_table_with_link_lists.sv
// ----------------------------------------------------------------------------
// remote_table_with_link_lists
// Table of remotes with ordered per-remote device link lists.
// ----------------------------------------------------------------------------
// Flow: one request at a time; ready returns in the cycle after the response
//   loads, and a completion waits while the response is held off.
// Reset: synchronous; all remotes inactive, active count zero, no clearing pass.
// ----------------------------------------------------------------------------
module remote_table_with_link_lists
    import rtll_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int LINKS   = LINKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    rtll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_stat      (stat),
        .o_req_ready (o_req_ready),
        .o_cmd       (cmd)
    );

    rtll_dpath #(
        .ENTRIES (ENTRIES),
        .LINKS   (LINKS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_rsp_ready (i_rsp_ready),
        .o_stat      (stat),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

// File: rtl/rtll_checker.sv
// ----------------------------------------------------------------------------
// rtll_checker
// Port-level checks for the remote table, bound to the top level.
// ----------------------------------------------------------------------------
module rtll_checker
    import rtll_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && !o_req_ready)
        else $error("response or ready after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in progress");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.status != ST_UNUSED)
        else $error("undefined status code");

    a_absent_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_NOT_FOUND || o_rsp.status == ST_TABLE_FULL)
        |-> o_rsp.link_count == 4'd0)
        else $error("link count for absent remote");

endmodule

bind remote_table_with_link_lists rtll_checker u_rtll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

// File: bench/remote_table_with_link_lists_tb.sv
// ----------------------------------------------------------------------------
// remote_table_with_link_lists_tb
// Self-checking bench for the remote table with per-remote link lists.
// Requests go in over a valid/ready channel with random gaps. A local table
// model predicts status, link count and active count for every accepted
// request. A response process compares each returned response, field by
// field, against the oldest prediction. Phases run directed cases, fill the
// table, grow and shrink link lists, churn all request kinds, back-pressure the
// response side long enough to stall the request side, and drain the table.
// ----------------------------------------------------------------------------
module remote_table_with_link_lists_tb;
    import rtll_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_SLOTS   = ENTRIES_DEF;
    localparam int LIST_DEPTH  = LINKS_DEF;
    localparam int IDLE_PCT    = 27;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REMOTE_POOL = 24;
    localparam int DEVICE_POOL = 12;
    localparam int UNDEF_W     = 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req_bus = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp_bus;

    logic idle_on = 1'b1;
    int hold_seq = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int fail_count = 0;

    logic              slot_used    [TBL_SLOTS];
    logic [ADDR_W-1:0] slot_key     [TBL_SLOTS];
    logic [3:0]        slot_links   [TBL_SLOTS];
    logic [ADDR_W-1:0] slot_devices [TBL_SLOTS][LIST_DEPTH];

    logic [ADDR_W-1:0] remote_pool [REMOTE_POOL];
    logic [ADDR_W-1:0] device_pool [DEVICE_POOL];

    t_rsp pending_answers[$];

    remote_table_with_link_lists uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_bus),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_bus)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_seq) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_seq;
        end
    end

    task automatic report_error(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    function automatic t_rsp table_apply(input t_req r);
        t_rsp rsp;
        int hit;
        int free;
        int n;
        int pos;
        int s;
        int k;
        int active;
        hit  = -1;
        free = -1;
        for (s = 0; s < TBL_SLOTS; s++) begin
            if (slot_used[s] && slot_key[s] == r.remote_addr && hit < 0) hit = s;
            if (!slot_used[s] && free < 0) free = s;
        end
        rsp.status = ST_OK;
        case (r.req_type)
            REQ_ADD: begin
                if (hit >= 0) begin
                    rsp.status = ST_PRESENT;
                end else if (free < 0) begin
                    rsp.status = ST_TABLE_FULL;
                end else begin
                    slot_used[free]  = 1'b1;
                    slot_key[free]   = r.remote_addr;
                    slot_links[free] = '0;
                    for (k = 0; k < LIST_DEPTH; k++) slot_devices[free][k] = '0;
                    hit = free;
                end
            end
            REQ_REMOVE: begin
                if (hit < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else begin
                    slot_used[hit]  = 1'b0;
                    slot_key[hit]   = '0;
                    slot_links[hit] = '0;
                    for (k = 0; k < LIST_DEPTH; k++) slot_devices[hit][k] = '0;
                    hit = -1;
                end
            end
            REQ_LINK, REQ_UNLINK: begin
                if (hit < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else begin
                    n = slot_links[hit];
                    if (n > LIST_DEPTH) n = LIST_DEPTH;
                    pos = n;
                    for (k = 0; k < n; k++) begin
                        if (pos == n && slot_devices[hit][k] == r.device_addr) pos = k;
                    end
                    if (r.req_type == REQ_LINK) begin
                        if (pos < n) begin
                            rsp.status = ST_LINKED;
                        end else if (n >= LIST_DEPTH) begin
                            rsp.status = ST_LINKS_FULL;
                        end else begin
                            slot_devices[hit][n] = r.device_addr;
                            slot_links[hit] = 4'(n + 1);
                        end
                    end else begin
                        if (pos >= n) begin
                            rsp.status = ST_NOT_LINKED;
                        end else begin
                            for (k = pos; k + 1 < n; k++) begin
                                slot_devices[hit][k] = slot_devices[hit][k + 1];
                            end
                            slot_devices[hit][n - 1] = '0;
                            slot_links[hit] = 4'(n - 1);
                        end
                    end
                end
            end
            default: begin
                if (hit < 0) rsp.status = ST_NOT_FOUND;
            end
        endcase
        active = 0;
        for (s = 0; s < TBL_SLOTS; s++) if (slot_used[s]) active++;
        rsp.link_count   = (hit >= 0) ? slot_links[hit] : 4'd0;
        rsp.active_count = 5'(active);
        return rsp;
    endfunction

    always @(posedge clk) begin : check_rsp
        t_rsp want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
                report_error("response with no request outstanding");
            end else begin
                want = pending_answers.pop_front();
                if (rsp_bus.status !== want.status) begin
                    report_error($sformatf("status got %0d want %0d",
                                           rsp_bus.status, want.status));
                end
                if (rsp_bus.link_count !== want.link_count) begin
                    report_error($sformatf("link_count got %0d want %0d",
                                           rsp_bus.link_count, want.link_count));
                end
                if (rsp_bus.active_count !== want.active_count) begin
                    report_error($sformatf("active_count got %0d want %0d",
                                           rsp_bus.active_count, want.active_count));
                end
            end
        end
        rsp_ready <= (hold_left == 0) && (!idle_on || $urandom_range(99) >= IDLE_PCT);
    end

    task automatic issue(input logic [2:0] kind, input logic [ADDR_W-1:0] raddr,
                         input logic [ADDR_W-1:0] daddr);
        t_req r;
        r.req_type    = kind;
        r.remote_addr = raddr;
        r.device_addr = daddr;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_bus   <= r;
        do @(posedge clk); while (!req_ready);
        pending_answers.push_back(table_apply(r));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
    endtask

    task automatic random_requests(input int count, input int w_add, input int w_remove,
                                   input int w_link, input int w_unlink, input int w_look,
                                   input int pool_used);
        int i;
        int roll;
        int total;
        logic [2:0] kind;
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] daddr;
        total = w_add + w_remove + w_link + w_unlink + w_look + UNDEF_W;
        for (i = 0; i < count; i++) begin
            roll = int'($urandom_range(total - 1));
            if (roll < w_add) kind = REQ_ADD;
            else if (roll < w_add + w_remove) kind = REQ_REMOVE;
            else if (roll < w_add + w_remove + w_link) kind = REQ_LINK;
            else if (roll < w_add + w_remove + w_link + w_unlink) kind = REQ_UNLINK;
            else if (roll < total - UNDEF_W) kind = REQ_LOOKUP;
            else kind = REQ_LOOKUP + 3'($urandom_range(1, 3));
            if ($urandom_range(99) < 8) raddr = ADDR_W'($urandom);
            else raddr = remote_pool[$urandom_range(pool_used - 1)];
            if ($urandom_range(99) < 10) daddr = ADDR_W'($urandom);
            else daddr = device_pool[$urandom_range(DEVICE_POOL - 1)];
            issue(kind, raddr, daddr);
        end
    endtask

    task automatic test_directed();
        issue(REQ_LOOKUP, 24'h000000, 24'h000000);
        issue(REQ_REMOVE, 24'hFFFFFF, 24'hFFFFFF);
        issue(REQ_LINK,   24'h123456, 24'h000001);
        issue(REQ_UNLINK, 24'h123456, 24'h000001);
        issue(REQ_ADD,    24'h000000, 24'hFFFFFF);
        issue(REQ_ADD,    24'hFFFFFF, 24'h000000);
        issue(REQ_ADD,    24'h000000, 24'h000000);
        issue(REQ_LINK,   24'h000000, 24'h000000);
        issue(REQ_LINK,   24'h000000, 24'hFFFFFF);
        issue(REQ_LINK,   24'h000000, 24'hABCDEF);
        issue(REQ_LINK,   24'h000000, 24'hFFFFFF);
        issue(REQ_UNLINK, 24'h000000, 24'h555555);
        issue(REQ_UNLINK, 24'h000000, 24'h000000);
        issue(REQ_LOOKUP, 24'h000000, 24'h000000);
        issue(REQ_LOOKUP + 3'd1, 24'h000000, 24'h000000);
        issue(REQ_LOOKUP + 3'd3, 24'hFFFFFF, 24'hFFFFFF);
        issue(REQ_LOOKUP + 3'd2, 24'h654321, 24'h000000);
        issue(REQ_REMOVE, 24'h000000, 24'h000000);
        issue(REQ_ADD,    24'h000000, 24'h000000);
        issue(REQ_LINK,   24'hFFFFFF, 24'h000000);
        issue(REQ_UNLINK, 24'hFFFFFF, 24'h000000);
        issue(REQ_REMOVE, 24'hFFFFFF, 24'h000000);
        drain();
    endtask

    task automatic test_fill_table();
        random_requests(200, 6, 1, 2, 1, 1, REMOTE_POOL);
        drain();
    endtask

    task automatic test_link_lists();
        random_requests(300, 1, 0, 6, 2, 1, 6);
        drain();
    endtask

    task automatic test_churn();
        idle_on <= 1'b0;
        random_requests(250, 2, 2, 2, 2, 2, REMOTE_POOL);
        drain();
        idle_on <= 1'b1;
    endtask

    task automatic test_backpressure();
        hold_seq <= hold_seq + 1;
        random_requests(40, 2, 1, 3, 1, 1, REMOTE_POOL);
        drain();
    endtask

    task automatic test_drain_table();
        random_requests(150, 1, 6, 1, 2, 2, REMOTE_POOL);
        drain();
    endtask

    initial begin
        int i;
        for (i = 0; i < TBL_SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_links[i] = '0;
            for (int k = 0; k < LIST_DEPTH; k++) slot_devices[i][k] = '0;
        end
        remote_pool[0] = 24'h000000;
        remote_pool[1] = 24'hFFFFFF;
        for (i = 2; i < REMOTE_POOL; i++) remote_pool[i] = ADDR_W'($urandom);
        device_pool[0] = 24'h000000;
        device_pool[1] = 24'hFFFFFF;
        for (i = 2; i < DEVICE_POOL; i++) device_pool[i] = ADDR_W'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_table();
        test_link_lists();
        test_churn();
        test_backpressure();
        test_drain_table();

        repeat (60) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
